// ===== sv/lcsf_pkg.sv =====
// Shared types and constants for the latency-capped sample FIFO.
// Holds the payload structs, register indexes and reset values.
// No dependencies.
package lcsf_pkg;

	localparam int REG_W           = 13;
	localparam int DATA_W          = 32;
	localparam int CFG_IDX_W       = 2;
	localparam int DEPTH_DEF       = 4096;
	localparam int SAMPLE_BITS_DEF = 32;

	localparam logic [REG_W-1:0] CAP_RESET = 13'd4096;
	localparam logic [REG_W-1:0] TGT_RESET = 13'd2048;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAPACITY = 2'd0,
		CFG_TARGET   = 2'd1
	} cfg_reg_e;

	typedef struct packed {
		logic              mode;
		logic [DATA_W-1:0] sample_in;
	} req_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] sample_out;
		logic              underrun;
		logic              became_nonempty;
		logic              dropped_oldest;
		logic [REG_W-1:0]  fill_level;
	} rsp_item_t;

	typedef struct packed {
		logic             has_data;
		logic             underrun;
		logic             became_nonempty;
		logic             dropped_oldest;
		logic [REG_W-1:0] fill_level;
	} res_meta_t;

endpackage

// ===== sv/lcsf_ram.sv =====
// Sample storage: single-port synchronous RAM with a registered read port.
// Self-contained; widths come from the top level.
module lcsf_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int SW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [SW-1:0] wdata,
	output logic [SW-1:0] rdata
);

	logic [SW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== sv/lcsf_ctrl.sv =====
// Pointer, occupancy and configuration control for the sample FIFO.
// Issues at most one RAM access per accepted transfer. Depends on lcsf_pkg.
module lcsf_ctrl #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int SW    = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  lcsf_pkg::req_item_t             item,
	input  logic                            cfg_we,
	input  logic [lcsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcsf_pkg::REG_W-1:0]      cfg_wdata,
	output logic                            ram_we,
	output logic                            ram_re,
	output logic [AW-1:0]                   ram_addr,
	output logic [SW-1:0]                   ram_wdata,
	output lcsf_pkg::res_meta_t             meta
);
	import lcsf_pkg::*;

	localparam int DW    = $clog2(DEPTH + 1);
	localparam int CMP_W = ((DW > REG_W) ? DW : REG_W) + 1;

	logic [AW-1:0]    rp_q, wp_q, rp_a, wp_a, rp_d, wp_d;
	logic [REG_W-1:0] occ_q, occ_a, occ_d;
	logic [REG_W-1:0] cap_q, tgt_q, c_eff, t_eff;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p,
	                                           input logic [REG_W-1:0] c);
		logic [CMP_W-1:0] nxt;
		nxt = CMP_W'(p) + CMP_W'(1);
		if (nxt >= CMP_W'(c)) begin
			wrap_inc = '0;
		end else begin
			wrap_inc = AW'(nxt);
		end
	endfunction

	always_comb begin
		if (cap_q == '0) begin
			c_eff = REG_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(DEPTH)) begin
			c_eff = REG_W'(DEPTH);
		end else begin
			c_eff = cap_q;
		end
		if (tgt_q == '0) begin
			t_eff = REG_W'(1);
		end else if (tgt_q > c_eff) begin
			t_eff = c_eff;
		end else begin
			t_eff = tgt_q;
		end
	end

	// The fill never exceeds the target after a write, so each drop step
	// removes at most one sample.
	always_comb begin
		rp_a      = rp_q;
		wp_a      = wp_q;
		occ_a     = occ_q;
		rp_d      = rp_q;
		wp_d      = wp_q;
		occ_d     = occ_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = rp_q;
		ram_wdata = item.sample_in[SW-1:0];
		meta      = '0;
		if (take) begin
			if (item.mode == MODE_WRITE) begin
				if (c_eff == REG_W'(1)) begin
					rp_a  = '0;
					wp_a  = '0;
					occ_a = '0;
				end else if (occ_q >= c_eff) begin
					rp_a  = wrap_inc(rp_q, c_eff);
					occ_a = occ_q - REG_W'(1);
				end
				meta.became_nonempty = (occ_a == '0);
				ram_we   = 1'b1;
				ram_addr = wp_a;
				wp_d     = wrap_inc(wp_a, c_eff);
				occ_d    = occ_a + REG_W'(1);
				rp_d     = rp_a;
				if (occ_d > t_eff) begin
					rp_d  = wrap_inc(rp_a, c_eff);
					occ_d = occ_d - REG_W'(1);
				end
				meta.dropped_oldest =
					((REG_W+1)'(occ_d) != ((REG_W+1)'(occ_q) + (REG_W+1)'(1)));
			end else if (occ_q != '0) begin
				meta.has_data = 1'b1;
				ram_re        = 1'b1;
				ram_addr      = rp_q;
				rp_d          = wrap_inc(rp_q, c_eff);
				occ_d         = occ_q - REG_W'(1);
			end else begin
				meta.underrun = 1'b1;
			end
		end
		meta.fill_level = occ_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= '0;
			wp_q  <= '0;
			occ_q <= '0;
			cap_q <= CAP_RESET;
			tgt_q <= TGT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAPACITY: begin
					cap_q <= cfg_wdata;
					rp_q  <= '0;
					wp_q  <= '0;
					occ_q <= '0;
				end
				CFG_TARGET: begin
					tgt_q <= cfg_wdata;
					rp_q  <= '0;
					wp_q  <= '0;
					occ_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (take) begin
			rp_q  <= rp_d;
			wp_q  <= wp_d;
			occ_q <= occ_d;
		end
	end

endmodule

// ===== sv/lcsf_resp.sv =====
// Response path: holds the item waiting for RAM data, then the output register.
// Drives the input stall. Depends on lcsf_pkg.
module lcsf_resp #(
	parameter int SW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  lcsf_pkg::res_meta_t  meta,
	input  logic [SW-1:0]        rdata,
	output logic                 req_stall,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output lcsf_pkg::rsp_item_t  rsp
);
	import lcsf_pkg::*;

	logic      s1_vld_q, rsp_vld_q, adv;
	res_meta_t meta_s1;
	rsp_item_t rsp_q;

	assign adv       = !(rsp_vld_q && rsp_stall);
	assign req_stall = s1_vld_q && !adv;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (take) begin
				s1_vld_q <= 1'b1;
			end else if (adv) begin
				s1_vld_q <= 1'b0;
			end
			if (adv) begin
				rsp_vld_q <= s1_vld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			meta_s1 <= meta;
		end
		if (adv && s1_vld_q) begin
			rsp_q.sample_out      <= meta_s1.has_data ? DATA_W'(rdata) : '0;
			rsp_q.underrun        <= meta_s1.underrun;
			rsp_q.became_nonempty <= meta_s1.became_nonempty;
			rsp_q.dropped_oldest  <= meta_s1.dropped_oldest;
			rsp_q.fill_level      <= meta_s1.fill_level;
		end
	end

endmodule

// ===== sv/latency_capped_sample_fifo.sv =====
// Top level of the latency-capped sample FIFO.
// Uses lcsf_pkg, lcsf_ctrl, lcsf_ram and lcsf_resp.
//
// Each request transfer on req either writes one sample (mode 0) or reads the
// oldest sample (mode 1). Every request gives exactly one response on rsp
// with the fill level after the request. A write into a full buffer drops the
// oldest sample, and after each write the oldest samples are dropped while
// the fill exceeds the target level. A read of an empty buffer answers zero
// with underrun set. Each response passes through the RAM-data stage and the
// output register. One request is taken per cycle while rsp keeps flowing;
// the pointer update and the RAM access happen as the request is taken.
// When rsp_stall holds, the response register keeps its transfer, one more
// request waits for RAM data, and req_stall then rises until rsp drains.
// Reset empties the buffer and loads capacity 4096 and target 2048. Writing
// either configuration register via cfg_we also empties the buffer; the user
// must do so only while no response is outstanding; it is not enforced.
module latency_capped_sample_fifo #(
	parameter int DEPTH       = lcsf_pkg::DEPTH_DEF,
	parameter int SAMPLE_BITS = lcsf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  lcsf_pkg::req_item_t            req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output lcsf_pkg::rsp_item_t            rsp,
	input  logic                           cfg_we,
	input  logic [lcsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lcsf_pkg::REG_W-1:0]     cfg_wdata
);
	import lcsf_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int SW = (SAMPLE_BITS < DATA_W) ? SAMPLE_BITS : DATA_W;

	logic          take, ram_we, ram_re;
	logic [AW-1:0] ram_addr;
	logic [SW-1:0] ram_wdata, ram_rdata;
	res_meta_t     meta;

	assign take = req_valid && !req_stall;

	lcsf_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.SW   (SW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (req),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.ram_we   (ram_we),
		.ram_re   (ram_re),
		.ram_addr (ram_addr),
		.ram_wdata(ram_wdata),
		.meta     (meta)
	);

	lcsf_ram #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.SW   (SW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	lcsf_resp #(
		.SW(SW)
	) u_resp (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.meta     (meta),
		.rdata    (ram_rdata),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

`ifndef SYNTHESIS
	a_one_ram_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("RAM write and read issued in the same cycle.");

	a_underrun_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.underrun) |->
			(rsp.fill_level == '0 && rsp.sample_out == '0 && !rsp.became_nonempty))
		else $error("Underrun response with data or a nonzero fill level.");

	a_stall_holds_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("Stalled response changed.");
`endif

endmodule

// ===== tb/latency_capped_sample_fifo_tb.sv =====
// Self-checking testbench for the latency-capped sample FIFO.
// Runs a directed table, then random traffic under random idling and stalls.
// Depends on lcsf_pkg and latency_capped_sample_fifo.
module latency_capped_sample_fifo_tb;
	import lcsf_pkg::*;

	localparam int FIFO_DEPTH = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int SEGMENTS = 6;
	localparam int SEG_ITEMS = 75;
	localparam int IDLE_PCT [4] = '{0, 88, 0, 24};
	localparam int STALL_PCT [4] = '{0, 0, 88, 24};

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

	typedef struct packed {
		row_kind_e            kind;
		req_item_t            item;
		logic                 typed;
		rsp_item_t            want;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [REG_W-1:0]     reg_val;
	} dir_row_t;

	localparam int DIR_ROWS = 34;
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{ROW_REQ, '{MODE_READ, 32'hFFFF_FFFF}, 1, '{32'h0, 1, 0, 0, 13'd0}, '0, '0},
		'{ROW_REQ, '{MODE_WRITE, 32'hFFFF_FFFF}, 1, '{32'h0, 0, 1, 0, 13'd1}, '0, '0},
		'{ROW_REQ, '{MODE_WRITE, 32'h0000_0000}, 1, '{32'h0, 0, 0, 0, 13'd2}, '0, '0},
		'{ROW_REQ, '{MODE_READ, 32'h0000_0000}, 1, '{32'hFFFF_FFFF, 0, 0, 0, 13'd1}, '0, '0},
		'{ROW_REQ, '{MODE_READ, 32'h5555_5555}, 1, '{32'h0, 0, 0, 0, 13'd0}, '0, '0},
		'{ROW_REQ, '{MODE_READ, 32'hAAAA_AAAA}, 1, '{32'h0, 1, 0, 0, 13'd0}, '0, '0},
		'{ROW_CFG, '0, 0, '0, CFG_CAPACITY, 13'd1},
		'{ROW_REQ, '{MODE_WRITE, 32'hA5A5_A5A5}, 1, '{32'h0, 0, 1, 0, 13'd1}, '0, '0},
		'{ROW_REQ, '{MODE_WRITE, 32'h5A5A_5A5A}, 1, '{32'h0, 0, 1, 1, 13'd1}, '0, '0},
		'{ROW_REQ, '{MODE_READ, 32'h0}, 1, '{32'h5A5A_5A5A, 0, 0, 0, 13'd0}, '0, '0},
		'{ROW_CFG, '0, 0, '0, CFG_CAPACITY, 13'd0},
		'{ROW_REQ, '{MODE_WRITE, 32'h1234_5678}, 1, '{32'h0, 0, 1, 0, 13'd1}, '0, '0},
		'{ROW_REQ, '{MODE_WRITE, 32'h9ABC_DEF0}, 1, '{32'h0, 0, 1, 1, 13'd1}, '0, '0},
		'{ROW_CFG, '0, 0, '0, CFG_CAPACITY, 13'd3},
		'{ROW_CFG, '0, 0, '0, CFG_TARGET, 13'd8191},
		'{ROW_REQ, '{MODE_WRITE, 32'h0000_0001}, 0, '0, '0, '0},
		'{ROW_REQ, '{MODE_WRITE, 32'h0000_0002}, 0, '0, '0, '0},
		'{ROW_REQ, '{MODE_WRITE, 32'h0000_0003}, 0, '0, '0, '0},
		'{ROW_REQ, '{MODE_WRITE, 32'h0000_0004}, 1, '{32'h0, 0, 0, 1, 13'd3}, '0, '0},
		'{ROW_REQ, '{MODE_READ, 32'h0}, 0, '0, '0, '0},
		'{ROW_CFG, '0, 0, '0, CFG_SPARE_A, 13'h1FFF},
		'{ROW_REQ, '{MODE_READ, 32'hFFFF_FFFF}, 0, '0, '0, '0},
		'{ROW_CFG, '0, 0, '0, CFG_TARGET, 13'd0},
		'{ROW_REQ, '{MODE_WRITE, 32'h0000_0007}, 0, '0, '0, '0},
		'{ROW_REQ, '{MODE_WRITE, 32'h0000_0008}, 1, '{32'h0, 0, 0, 1, 13'd1}, '0, '0},
		'{ROW_REQ, '{MODE_READ, 32'h0}, 0, '0, '0, '0},
		'{ROW_CFG, '0, 0, '0, CFG_CAPACITY, 13'd8191},
		'{ROW_CFG, '0, 0, '0, CFG_TARGET, 13'd2},
		'{ROW_CFG, '0, 0, '0, CFG_SPARE_B, 13'd0},
		'{ROW_REQ, '{MODE_WRITE, 32'hDEAD_BEEF}, 0, '0, '0, '0},
		'{ROW_REQ, '{MODE_WRITE, 32'h8000_0001}, 0, '0, '0, '0},
		'{ROW_REQ, '{MODE_WRITE, 32'h7FFF_FFFE}, 1, '{32'h0, 0, 0, 1, 13'd2}, '0, '0},
		'{ROW_REQ, '{MODE_READ, 32'h0}, 0, '0, '0, '0},
		'{ROW_REQ, '{MODE_READ, 32'h0}, 0, '0, '0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_item_t            req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_item_t            rsp;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_wdata = '0;

	logic [DATA_W-1:0] shadow_store [FIFO_DEPTH];
	int                rd_idx;
	int                wr_idx;
	int                fill;
	logic [REG_W-1:0]  cap_reg;
	logic [REG_W-1:0]  tgt_reg;
	rsp_item_t         pending_results [$];
	rsp_item_t         head_result;
	int                err_count = 0;
	int                cycle_count = 0;
	int                idle_pct = 0;
	int                stall_pct = 0;

	latency_capped_sample_fifo DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic flag_error(input string msg);
		$display("ERROR: %s", msg);
		err_count++;
	endtask

	function automatic void clear_ring();
		rd_idx = 0;
		wr_idx = 0;
		fill = 0;
	endfunction

	function automatic void discard_oldest(input int n, input int c);
		if (n == 0) return;
		if (n >= fill) begin
			clear_ring();
			return;
		end
		rd_idx = (rd_idx + n) % c;
		fill -= n;
	endfunction

	function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [REG_W-1:0] val);
		if (idx == CFG_CAPACITY) begin
			cap_reg = val;
			clear_ring();
		end else if (idx == CFG_TARGET) begin
			tgt_reg = val;
			clear_ring();
		end
	endfunction

	function automatic rsp_item_t predict_fifo_result(input req_item_t item);
		rsp_item_t r;
		int        c;
		int        t;
		int        prior;
		r = '0;
		c = int'(cap_reg);
		if (c < 1) c = 1;
		if (c > FIFO_DEPTH) c = FIFO_DEPTH;
		t = int'(tgt_reg);
		if (t < 1) t = 1;
		if (t > c) t = c;
		if (item.mode == MODE_WRITE) begin
			prior = fill;
			if (c <= 1) clear_ring();
			if (fill + 1 > c) discard_oldest(fill + 1 - c, c);
			r.became_nonempty = (fill == 0);
			shadow_store[wr_idx] = item.sample_in;
			wr_idx = (wr_idx + 1) % c;
			fill++;
			if (fill > t) discard_oldest(fill - t, c);
			r.dropped_oldest = (fill != prior + 1);
		end else if (fill > 0) begin
			r.sample_out = shadow_store[rd_idx];
			rd_idx = (rd_idx + 1) % c;
			fill--;
		end else begin
			r.underrun = 1'b1;
		end
		r.fill_level = REG_W'(fill);
		return r;
	endfunction

	task automatic send_req(input req_item_t item, input logic typed, input rsp_item_t typed_rsp);
		rsp_item_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predicted = predict_fifo_result(item);
		pending_results.push_back(typed ? typed_rsp : predicted);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg_write(idx, val);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				flag_error("response transfer with nothing outstanding");
			end else begin
				head_result = pending_results.pop_front();
				if (rsp.sample_out !== head_result.sample_out)
					flag_error($sformatf("sample_out got %h want %h",
						rsp.sample_out, head_result.sample_out));
				if (rsp.underrun !== head_result.underrun)
					flag_error($sformatf("underrun got %b want %b",
						rsp.underrun, head_result.underrun));
				if (rsp.became_nonempty !== head_result.became_nonempty)
					flag_error($sformatf("became_nonempty got %b want %b",
						rsp.became_nonempty, head_result.became_nonempty));
				if (rsp.dropped_oldest !== head_result.dropped_oldest)
					flag_error($sformatf("dropped_oldest got %b want %b",
						rsp.dropped_oldest, head_result.dropped_oldest));
				if (rsp.fill_level !== head_result.fill_level)
					flag_error($sformatf("fill_level got %0d want %0d",
						rsp.fill_level, head_result.fill_level));
			end
		end
	end

	initial begin
		int               phase;
		int               seg;
		int               n;
		int               write_pct;
		logic [REG_W-1:0] cap_pick;
		logic [REG_W-1:0] tgt_pick;
		req_item_t        item;
		clear_ring();
		cap_reg = CAP_RESET;
		tgt_reg = TGT_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TAB[i].kind == ROW_CFG)
				write_reg(DIR_TAB[i].reg_idx, DIR_TAB[i].reg_val);
			else
				send_req(DIR_TAB[i].item, DIR_TAB[i].typed, DIR_TAB[i].want);
		end

		for (phase = 0; phase < 4; phase++) begin
			idle_pct = IDLE_PCT[phase];
			stall_pct = STALL_PCT[phase];
			for (seg = 0; seg < SEGMENTS; seg++) begin
				case ($urandom_range(7))
					0: cap_pick = 13'd0;
					1: cap_pick = 13'd1;
					2: cap_pick = 13'd2;
					3: cap_pick = REG_W'($urandom_range(3, 16));
					4: cap_pick = REG_W'($urandom_range(17, 300));
					5: cap_pick = 13'd4096;
					6: cap_pick = REG_W'($urandom_range(4097, 8191));
					default: cap_pick = REG_W'($urandom_range(1, 64));
				endcase
				case ($urandom_range(5))
					0: tgt_pick = 13'd0;
					1: tgt_pick = 13'd1;
					2: tgt_pick = REG_W'($urandom_range(2, 8));
					3: tgt_pick = cap_pick;
					4: tgt_pick = 13'd8191;
					default: tgt_pick = REG_W'($urandom_range(0, 8191));
				endcase
				if ($urandom_range(1)) begin
					write_reg(CFG_CAPACITY, cap_pick);
					write_reg(CFG_TARGET, tgt_pick);
				end else begin
					write_reg(CFG_TARGET, tgt_pick);
					write_reg(CFG_CAPACITY, cap_pick);
				end
				if ($urandom_range(7) == 0)
					write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B,
						REG_W'($urandom));
				write_pct = 25 + 23 * $urandom_range(3);
				for (n = 0; n < SEG_ITEMS; n++) begin
					item.mode = ($urandom_range(99) < write_pct) ? MODE_WRITE : MODE_READ;
					item.sample_in = $urandom;
					send_req(item, 1'b0, '0);
				end
			end
		end

		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
sv/lcsf_pkg.sv
sv/lcsf_ram.sv
sv/lcsf_ctrl.sv
sv/lcsf_resp.sv
sv/latency_capped_sample_fifo.sv
tb/latency_capped_sample_fifo_tb.sv
